### sv/sfcc_pkg.sv
// sfcc_pkg: shared types, constants and the byte-wide crc update for the
// sensor frame crc checker; depends on nothing
package sfcc_pkg;

  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // byte positions inside one eight-byte frame
  localparam logic [2:0] POS_START   = 3'd0;
  localparam logic [2:0] POS_PAYLOAD = 3'd2;
  localparam logic [2:0] POS_CRC_LO  = 3'd6;
  localparam logic [2:0] POS_CRC_HI  = 3'd7;

  localparam int TDATA_W = 40;

  typedef struct packed {
    logic               crc_ok;
    logic signed [15:0] temperature;
    logic signed [15:0] humidity;
  } result_t;

  function automatic logic [15:0] crc_byte_update(input logic [15:0] crc_in,
                                                  input logic [7:0]  data);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

### sv/sensor_frame_crc_checker.sv
// sensor_frame_crc_checker: top level, frame tracking, crc and value hold
// depends on sfcc_pkg and sfcc_result_reg
//
// Usage: the input stream carries one byte of a sensor response frame per
// request in s_axis_tdata, with s_axis_tuser set on byte 0 of a new frame
// (it restarts the count; without it the count wraps after byte 7).
// A reflected crc-16 (poly 0xA001, init 0xFFFF) runs over bytes 0..5 and is
// compared with bytes 6 (low) and 7 (high). Byte 7 produces one result on
// the output stream: crc match flag, temperature and humidity (bytes 4-5 and
// 2-3, big-endian); on a mismatch the last good values are repeated.
// Throughput: one byte per cycle while no byte 7 waits; the byte crc update
// is one combinational step feeding the accumulator register. The result
// appears the cycle after byte 7 is taken, held in a single output register.
// Stall: while a result waits in the output register, bytes 0..6 are still
// taken; only a byte 7 waits until the result is taken or taken that cycle.
// Reset: position 0, crc 0xFFFF, held values 0, no pending result.
module sensor_frame_crc_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // bits 7:0 data_byte
  input  logic [7:0]  s_axis_tdata,
  // bit 0 first
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // bit 0 crc_ok, bits 16:1 temperature, bits 32:17 humidity, rest zero
  output logic [39:0] m_axis_tdata
);

  logic [2:0]        byte_position;
  logic [15:0]       crc_accumulator;
  logic [7:0]        payload_bytes [4];
  logic [7:0]        crc_low_byte;
  logic [15:0]       held_temperature;
  logic [15:0]       held_humidity;

  logic [2:0]        pos;
  logic [15:0]       crc_base;
  logic [15:0]       crc_next;
  logic [1:0]        payload_idx;
  logic              last_byte;
  logic              accept;
  logic              push;
  logic              crc_ok;
  logic [15:0]       temperature_next;
  logic [15:0]       humidity_next;
  sfcc_pkg::result_t result;

  assign pos       = s_axis_tuser ? sfcc_pkg::POS_START : byte_position;
  assign last_byte = (pos == sfcc_pkg::POS_CRC_HI);
  assign s_axis_tready = !(last_byte && m_axis_tvalid && !m_axis_tready);
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign push      = accept && last_byte;

  assign crc_base    = (pos == sfcc_pkg::POS_START) ? sfcc_pkg::CRC_INIT : crc_accumulator;
  assign crc_next    = sfcc_pkg::crc_byte_update(crc_base, s_axis_tdata);
  assign payload_idx = 2'(pos - sfcc_pkg::POS_PAYLOAD);

  assign crc_ok = ({s_axis_tdata, crc_low_byte} == crc_accumulator);
  assign humidity_next    = crc_ok ? {payload_bytes[0], payload_bytes[1]} : held_humidity;
  assign temperature_next = crc_ok ? {payload_bytes[2], payload_bytes[3]} : held_temperature;

  always_comb begin
    result.crc_ok      = crc_ok;
    result.temperature = temperature_next;
    result.humidity    = humidity_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= sfcc_pkg::POS_START;
      crc_accumulator  <= sfcc_pkg::CRC_INIT;
      held_temperature <= 16'd0;
      held_humidity    <= 16'd0;
    end else if (accept) begin
      byte_position <= pos + 3'd1;
      if (pos < sfcc_pkg::POS_CRC_LO) begin
        crc_accumulator <= crc_next;
      end
      if (last_byte) begin
        held_temperature <= temperature_next;
        held_humidity    <= humidity_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (pos >= sfcc_pkg::POS_PAYLOAD && pos < sfcc_pkg::POS_CRC_LO) begin
        payload_bytes[payload_idx] <= s_axis_tdata;
      end
      if (pos == sfcc_pkg::POS_CRC_LO) begin
        crc_low_byte <= s_axis_tdata;
      end
    end
  end

  sfcc_result_reg u_result_reg (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .result        (result),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // a result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    push |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result pushed over a pending result");

  // a taken last byte always leaves a result on the output
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    push |=> m_axis_tvalid)
    else $error("no result after last byte");

  // held values change only when a frame closes
  a_hold_stable: assert property (@(posedge clk) disable iff (rst)
    !push |=> ($stable(held_temperature) && $stable(held_humidity)))
    else $error("held values changed outside a frame end");

endmodule

### sv/sfcc_result_reg.sv
// sfcc_result_reg: output register of the result stream with its handshake
// depends on sfcc_pkg for the result type and the tdata width
module sfcc_result_reg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  sfcc_pkg::result_t             result,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // bit 0 crc_ok, bits 16:1 temperature, bits 32:17 humidity, rest zero
  output logic [sfcc_pkg::TDATA_W-1:0]  m_axis_tdata
);

  sfcc_pkg::result_t held;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (push) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      held <= result;
    end
  end

  assign m_axis_tdata = {7'd0, held.humidity, held.temperature, held.crc_ok};

endmodule
